/* rtl/core/gcs_pkg.sv */
// Shared types and constants for the gated candidate selector.
// Used by gcs_ctrl, gcs_dp and gated_candidate_selector; no dependencies.
package gcs_pkg;

  localparam int IDX_W   = 8;
  localparam int SHAPE_W = 17;
  localparam int POS_W   = 16;
  localparam int SCORE_W = 18;
  localparam int CNT_W   = 9;
  localparam int WGT_W   = 17;
  localparam int IN_DATA_W  = 80;   // 73 field bits padded to bytes
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 56;   // 53 field bits padded to bytes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int SEQ_W      = 6;

  localparam logic [SEQ_W-1:0] ROOT_LAST = 6'd32;
  localparam logic [SEQ_W-1:0] DIV_LAST  = 6'd36;

  localparam logic [15:0] MIN_GATE   = 16'd50;
  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic signed [SCORE_W-1:0] NEG_ONE_Q16 = -18'sd65536;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_TRK_X  = 3'd1,
    REG_TRK_Y  = 3'd2,
    REG_TRK_Z  = 3'd3,
    REG_GATE   = 3'd4,
    REG_SHAPE_W = 3'd5,
    REG_TEMP_W = 3'd6
  } cfg_reg_t;

  // operand selection of the shared multiplier
  typedef enum logic [2:0] {
    MUL_DX = 3'd0,
    MUL_DY = 3'd1,
    MUL_DZ = 3'd2,
    MUL_GG = 3'd3,
    MUL_WS = 3'd4,
    MUL_WT = 3'd5
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    mul_en;
    mul_op_t mul_op;
    logic    root_init;
    logic    root_step;
    logic    div_init;
    logic    div_mix;
    logic    div_step;
    logic    upd;
  } cmd_t;

  typedef struct packed {
    logic in_track;   // incoming beat needs the mixed score
    logic wzero;      // both weights zero
    logic out_full;   // result register held by downstream
    logic last;       // captured record closes the frame
  } sts_t;

endpackage

/* rtl/core/gated_candidate_selector.sv */
// Shape-mode records and records that do not compete go straight to update; competing
// track records with both weights zero run the multiplier only, scored track records add a
// 32-step square root and two 36-step divisions on one shared restoring divider.
// One record at a time; the result sits in an output register in the cycle after the
// closing record's update, and a closing record waits only while that register is held.
// Reset: synchronous active-low rst_n restores config defaults and clears the frame.
module gated_candidate_selector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gcs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gcs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // clu_id[7:0], shape_score[24:8], centroid_x[40:25],
  // centroid_y[56:41], centroid_z[72:57], zero pad
  input  logic [gcs_pkg::IN_DATA_W-1:0]       in_tdata,
  // valid_req[0], best_hint[1], present[2]
  input  logic [gcs_pkg::IN_USER_W-1:0]       in_tuser,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // chosen_index[7:0], chosen_score[25:8], runner_up_score[43:26],
  // valid_total[52:44], zero pad
  output logic [gcs_pkg::OUT_DATA_W-1:0]      out_tdata,
  // found
  output logic                                out_tuser
);
  import gcs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  gcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gcs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

/* rtl/core/gcs_ctrl.sv */
// Sequencer for the gated candidate selector.
// Depends on gcs_pkg; drives gcs_dp through cmd_t, reads sts_t.
module gcs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  gcs_pkg::sts_t sts,
  output gcs_pkg::cmd_t cmd
);
  import gcs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_ROOT = 7'b0000100,
    S_DIV1 = 7'b0001000,
    S_MIX  = 7'b0010000,
    S_DIV2 = 7'b0100000,
    S_UPD  = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [SEQ_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 6'd1;
    cmd       = '0;
    cmd.mul_op = MUL_DX;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.in_track ? S_MUL : S_UPD;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        case (cnt_r[1:0])
          2'd0:    cmd.mul_op = MUL_DX;
          2'd1:    cmd.mul_op = MUL_DY;
          2'd2:    cmd.mul_op = MUL_DZ;
          default: cmd.mul_op = MUL_GG;
        endcase
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          state_nxt = sts.wzero ? S_UPD : S_ROOT;
        end
      end
      S_ROOT: begin
        cmd.root_init = (cnt_r == '0);
        cmd.root_step = (cnt_r != '0);
        if (cnt_r == ROOT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        cmd.div_init = (cnt_r == '0);
        cmd.div_step = (cnt_r != '0);
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = cnt_r[0] ? MUL_WT : MUL_WS;
        if (cnt_r[0]) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd.div_init = (cnt_r == '0);
        cmd.div_mix  = 1'b1;
        cmd.div_step = (cnt_r != '0);
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cnt_nxt = '0;
        if (!(sts.last && sts.out_full)) begin
          cmd.upd   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        cnt_nxt   = '0;
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && sts.last && sts.out_full) |=> state_r == S_UPD)
    else $error("closing record left update while result still held");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !cmd.load)
    else $error("record loaded while sequencer busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DIV_LAST)
    else $error("step counter out of range");
`endif

endmodule

/* rtl/core/gcs_dp.sv */
// Datapath: config registers, record capture, shared multiplier,
// bit-serial square root, restoring divider, frame state and result register.
// Depends on gcs_pkg; controlled by gcs_ctrl.
module gcs_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [gcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gcs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [gcs_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [gcs_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gcs_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser,
  input  gcs_pkg::cmd_t                    cmd,
  output gcs_pkg::sts_t                    sts
);
  import gcs_pkg::*;

  // configuration
  logic              mode_cfg_r;
  logic signed [15:0] tx_r, ty_r, tz_r;
  logic [15:0]       gate_r;
  logic [WGT_W-1:0]  ws_r, wt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_cfg_r <= 1'b0;
      tx_r <= '0; ty_r <= '0; tz_r <= '0;
      gate_r <= 16'd500;
      ws_r <= 17'd32768;
      wt_r <= 17'd32768;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE:    mode_cfg_r <= cfg_data[0];
        REG_TRK_X:   tx_r <= cfg_data[15:0];
        REG_TRK_Y:   ty_r <= cfg_data[15:0];
        REG_TRK_Z:   tz_r <= cfg_data[15:0];
        REG_GATE:    gate_r <= cfg_data[15:0];
        REG_SHAPE_W: ws_r <= cfg_data;
        REG_TEMP_W:  wt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured record
  logic               valid_r, hint_r, present_r, last_r, mode_r;
  logic [IDX_W-1:0]   idx_r;
  logic [SHAPE_W-1:0] shape_r;
  logic [POS_W-1:0]   cx_r, cy_r, cz_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      valid_r   <= in_tuser[0];
      hint_r    <= in_tuser[1];
      present_r <= in_tuser[2];
      idx_r     <= in_tdata[7:0];
      shape_r   <= in_tdata[24:8];
      cx_r      <= in_tdata[40:25];
      cy_r      <= in_tdata[56:41];
      cz_r      <= in_tdata[72:57];
      last_r    <= in_tlast;
      mode_r    <= mode_cfg_r;
    end
  end

  // gate floor and weight sum
  logic [15:0] g;
  logic [17:0] wsum;
  assign g    = (gate_r < MIN_GATE) ? MIN_GATE : gate_r;
  assign wsum = {1'b0, ws_r} + {1'b0, wt_r};

  // shared multiplier
  logic signed [16:0] dx, dy, dz;
  logic signed [17:0] op_a, op_b;
  logic signed [35:0] prod;
  logic [SHAPE_W-1:0] shape_cl, close_w;
  logic [34:0]        d2_r, num_r;
  logic [31:0]        gg_r;
  logic               in_gate;
  logic [35:0]        dq_r;

  assign dx = {cx_r[15], cx_r} - {tx_r[15], tx_r};
  assign dy = {cy_r[15], cy_r} - {ty_r[15], ty_r};
  assign dz = {cz_r[15], cz_r} - {tz_r[15], tz_r};
  assign shape_cl = (shape_r > ONE_Q16) ? ONE_Q16 : shape_r;
  assign in_gate  = d2_r < {3'b000, gg_r};
  assign close_w  = in_gate ? (ONE_Q16 - dq_r[16:0]) : '0;

  always_comb begin
    case (cmd.mul_op)
      MUL_DX:  begin op_a = {dx[16], dx}; op_b = {dx[16], dx}; end
      MUL_DY:  begin op_a = {dy[16], dy}; op_b = {dy[16], dy}; end
      MUL_DZ:  begin op_a = {dz[16], dz}; op_b = {dz[16], dz}; end
      MUL_GG:  begin op_a = {2'b00, g};   op_b = {2'b00, g};   end
      MUL_WS:  begin op_a = {1'b0, ws_r}; op_b = {1'b0, shape_cl}; end
      MUL_WT:  begin op_a = {1'b0, wt_r}; op_b = {1'b0, close_w};  end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end
  assign prod = op_a * op_b;

  // accumulate squared distance, gate square and weighted sum
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d2_r <= '0;
    end else if (cmd.mul_en) begin
      case (cmd.mul_op)
        MUL_DX, MUL_DY, MUL_DZ: d2_r <= d2_r + {1'b0, prod[33:0]};
        MUL_GG:  gg_r  <= prod[31:0];
        MUL_WS:  num_r <= prod[34:0];
        MUL_WT:  num_r <= num_r + prod[34:0];
        default: ;
      endcase
    end
  end

  // square root of d2[31:0] * 2^32, two radicand bits per step
  logic [63:0] rv_r;
  logic [34:0] rem_r, rem_t, trial;
  logic [31:0] root_r;
  logic        rge;

  assign rem_t = {rem_r[32:0], rv_r[63:62]};
  assign trial = {1'b0, root_r, 2'b01};
  assign rge   = rem_t >= trial;

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rv_r   <= {d2_r[31:0], 32'd0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rv_r   <= {rv_r[61:0], 2'b00};
      rem_r  <= rge ? (rem_t - trial) : rem_t;
      root_r <= {root_r[30:0], rge};
    end
  end

  // restoring divider: distance / gate, then weighted sum / weight sum
  logic [17:0] dvs_r, drem_r;
  logic [18:0] dt;
  logic        dge;

  assign dt  = {drem_r, dq_r[35]};
  assign dge = dt >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dq_r   <= cmd.div_mix ? {1'b0, num_r} : {4'd0, root_r};
      dvs_r  <= cmd.div_mix ? wsum : {2'b00, g};
      drem_r <= '0;
    end else if (cmd.div_step) begin
      drem_r <= dge ? 18'(dt - {1'b0, dvs_r}) : dt[17:0];
      dq_r   <= {dq_r[34:0], dge};
    end
  end

  // frame state
  logic signed [SCORE_W-1:0] top_r, top_nxt, sec_r, sec_nxt, score;
  logic [IDX_W-1:0]          tidx_r, tidx_nxt;
  logic                      have_r, have_nxt, compete, win;
  logic [CNT_W-1:0]          seen_r, seen_nxt;

  always_comb begin
    if (!mode_r)            score = {1'b0, shape_r};
    else if (sts.wzero)     score = '0;
    else                    score = dq_r[17:0];
    compete  = valid_r && (!mode_r || present_r);
    win      = (!mode_r && hint_r) || (score > top_r);
    top_nxt  = top_r;
    sec_nxt  = sec_r;
    tidx_nxt = tidx_r;
    have_nxt = have_r;
    seen_nxt = seen_r;
    if (valid_r && seen_r != 9'd511) seen_nxt = seen_r + 9'd1;
    if (compete) begin
      if (win) begin
        if (have_r && top_r > sec_r) sec_nxt = top_r;
        top_nxt  = score;
        tidx_nxt = idx_r;
        have_nxt = 1'b1;
      end else if (score > sec_r) begin
        sec_nxt = score;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.upd && last_r)) begin
      top_r  <= NEG_ONE_Q16;
      sec_r  <= NEG_ONE_Q16;
      tidx_r <= '0;
      have_r <= 1'b0;
      seen_r <= '0;
    end else if (cmd.upd) begin
      top_r  <= top_nxt;
      sec_r  <= sec_nxt;
      tidx_r <= tidx_nxt;
      have_r <= have_nxt;
      seen_r <= seen_nxt;
    end
  end

  // result register
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.upd && last_r) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && last_r) begin
      out_tuser <= have_nxt;
      out_tdata <= {3'b000, seen_nxt, sec_nxt,
                    have_nxt ? top_nxt : 18'sd0,
                    have_nxt ? tidx_nxt : 8'd0};
    end
  end

  assign out_tvalid   = out_valid_r;
  assign sts.in_track = in_tuser[0] && in_tuser[2] && mode_cfg_r;
  assign sts.wzero    = (wsum == '0);
  assign sts.out_full = out_valid_r && !out_tready;
  assign sts.last     = last_r;

`ifndef NO_ASSERTIONS
  a_mix_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && mode_r && compete && !sts.wzero) |-> dq_r <= 36'd65536)
    else $error("mixed score above one");
  a_close_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mul_en && cmd.mul_op == MUL_WS && in_gate) |-> dq_r[35:16] == '0)
    else $error("normalized distance inside gate reaches one");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && last_r) |-> !sts.out_full)
    else $error("result overwritten while held");
`endif

endmodule

/* verif/tb.sv */
// Self-checking testbench for gated_candidate_selector: frames of cluster
// records in shape and track mode against an in-bench scoring predictor.
// Depends on gcs_pkg and the gated_candidate_selector RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gcs_pkg::*;

  // one cluster record as driven on the input stream
  typedef struct {
    bit               vreq;
    bit               hint;
    bit               pres;
    bit [7:0]         idx;
    bit [16:0]        shape;
    bit signed [15:0] cx, cy, cz;
    bit               last;
  } rec_t;

  // one frame choice as seen on the output stream
  typedef struct packed {
    bit               found;
    bit [7:0]         idx;
    bit signed [17:0] score;
    bit signed [17:0] runner;
    bit [8:0]         total;
  } pick_t;

  // directed row: a record and, where obvious, the typed-in choice
  typedef struct {
    rec_t  r;
    bit    typed;
    pick_t p;
  } row_t;

  logic                  clk, rst_n;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid, in_tready, in_tlast;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid, out_tready, out_tuser;
  logic [OUT_DATA_W-1:0] out_tdata;

  gated_candidate_selector dut (.*);

  // register copies
  bit               mode_r;
  bit signed [15:0] trk_x, trk_y, trk_z;
  bit [15:0]        gate_r;
  bit [16:0]        wshape, wtemp;
  // frame state copies
  longint           best_sc, second_sc;
  bit [7:0]         best_idx;
  bit               have_best;
  int               nvalid;

  pick_t picks_q[$];
  int    errors = 0;
  int    idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: done, errors");
    $finish;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // weighted mix of clamped shape score and track closeness
  function automatic longint track_score(rec_t r);
    longint unsigned g, d2, q, nd, cl, sh, ws, wt;
    longint dx, dy, dz;
    g  = (gate_r < MIN_GATE) ? MIN_GATE : gate_r;
    ws = wshape;
    wt = wtemp;
    dx = longint'(r.cx) - longint'(trk_x);
    dy = longint'(r.cy) - longint'(trk_y);
    dz = longint'(r.cz) - longint'(trk_z);
    d2 = dx * dx + dy * dy + dz * dz;
    cl = 0;
    if (ws + wt == 0) return 0;
    if (d2 < g * g) begin
      q  = isqrt(d2 << 32);
      nd = q / g;
      cl = (nd >= 65536) ? 0 : 65536 - nd;
    end
    sh = (r.shape > ONE_Q16) ? 65536 : r.shape;
    return longint'((ws * sh + wt * cl) / (ws + wt));
  endfunction

  function automatic void clear_frame();
    best_sc   = -65536;
    second_sc = -65536;
    best_idx  = 0;
    have_best = 0;
    nvalid    = 0;
  endfunction

  function automatic void offer(longint sc, bit [7:0] idx, bit force_pick);
    if (force_pick || sc > best_sc) begin
      if (have_best && best_sc > second_sc) second_sc = best_sc;
      best_sc   = sc;
      best_idx  = idx;
      have_best = 1;
    end else if (sc > second_sc) begin
      second_sc = sc;
    end
  endfunction

  // advance the frame state by one record; returns 1 with the choice on last
  function automatic bit select_step(rec_t r, output pick_t p);
    p = '{0, 0, 0, 0, 0};
    if (r.vreq) begin
      if (nvalid < 511) nvalid++;
      if (!mode_r) offer(r.shape, r.idx, r.hint);
      else if (r.pres) offer(track_score(r), r.idx, 0);
    end
    if (!r.last) return 0;
    p.found  = have_best;
    p.idx    = have_best ? best_idx : 8'd0;
    p.score  = have_best ? best_sc[17:0] : 18'd0;
    p.runner = second_sc[17:0];
    p.total  = nvalid[8:0];
    clear_frame();
    return 1;
  endfunction

  task automatic write_reg(cfg_reg_t idx, bit [16:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_MODE:    mode_r = val[0];
      REG_TRK_X:   trk_x  = val[15:0];
      REG_TRK_Y:   trk_y  = val[15:0];
      REG_TRK_Z:   trk_z  = val[15:0];
      REG_GATE:    gate_r = val[15:0];
      REG_SHAPE_W: wshape = val;
      REG_TEMP_W:  wtemp  = val;
      default: ;
    endcase
  endtask

  // send one record; we are at a falling edge on entry and on exit
  task automatic send_rec(rec_t r, bit typed, pick_t tp);
    pick_t p;
    if (idle_mode == 1 || idle_mode == 3) begin
      while ($urandom_range(0, 99) < ((idle_mode == 1) ? 87 : 9)) begin
        in_tvalid = 0;
        @(negedge clk);
      end
    end
    in_tvalid = 1;
    in_tuser  = {r.pres, r.hint, r.vreq};
    in_tlast  = r.last;
    in_tdata  = {7'd0, r.cz, r.cy, r.cx, r.shape, r.idx};
    do @(posedge clk); while (!in_tready);
    if (select_step(r, p)) begin
      if (typed) p = tp;
      picks_q.insert(picks_q.size(), p);
    end
    @(negedge clk);
    in_tvalid = 0;
  endtask

  // receiver backpressure
  always @(negedge clk) begin
    case (idle_mode)
      2:       out_tready <= ($urandom_range(0, 99) >= 87);
      3:       out_tready <= ($urandom_range(0, 99) >= 9);
      default: out_tready <= 1;
    endcase
  end

  // result checker
  always @(posedge clk) begin
    pick_t a, e;
    if (rst_n && out_tvalid && out_tready) begin
      a.found  = out_tuser;
      a.idx    = out_tdata[7:0];
      a.score  = out_tdata[25:8];
      a.runner = out_tdata[43:26];
      a.total  = out_tdata[52:44];
      if (picks_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat idx=%0d", a.idx);
      end else begin
        e = picks_q.pop_front();
        if (a != e) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch exp f=%0d i=%0d s=%0d r=%0d n=%0d",
                     e.found, e.idx, e.score, e.runner, e.total);
            $display("         got f=%0d i=%0d s=%0d r=%0d n=%0d",
                     a.found, a.idx, a.score, a.runner, a.total);
          end
        end
      end
    end
  end

  function automatic rec_t rand_rec(bit last);
    rec_t r;
    int   g, off;
    g      = (gate_r < MIN_GATE) ? MIN_GATE : gate_r;
    r.vreq = ($urandom_range(0, 9) != 0);
    r.hint = ($urandom_range(0, 9) == 0);
    r.pres = ($urandom_range(0, 9) != 0);
    r.idx  = $urandom;
    r.shape = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    r.last = last;
    if ($urandom_range(0, 3) == 0) begin
      r.cx = $urandom; r.cy = $urandom; r.cz = $urandom;
    end else begin
      if (g > 20000) g = 20000;
      off = int'(trk_x) + $urandom_range(0, 2 * g) - g;
      r.cx = (off > 32767) ? 32767 : (off < -32768) ? -32768 : off;
      off = int'(trk_y) + $urandom_range(0, g) - g / 2;
      r.cy = (off > 32767) ? 32767 : (off < -32768) ? -32768 : off;
      off = int'(trk_z) + $urandom_range(0, g) - g / 2;
      r.cz = (off > 32767) ? 32767 : (off < -32768) ? -32768 : off;
    end
    return r;
  endfunction

  task automatic settle();
    wait (picks_q.size() == 0);
    repeat (130) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    row_t  rows[$];
    pick_t none;
    rec_t  r;
    int    n, len;
    none = '{0, 0, 0, 0, 0};
    rst_n = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    in_tvalid = 0; in_tdata = 0; in_tuser = 0; in_tlast = 0; out_tready = 1;
    mode_r = 0; trk_x = 0; trk_y = 0; trk_z = 0;
    gate_r = 500; wshape = 32768; wtemp = 32768;
    clear_frame();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: shape mode after reset
    rows = '{
      // invalid record alone: no candidate
      '{'{0, 0, 1, 8'd5, 17'd1000, 0, 0, 0, 1}, 1, '{0, 0, 0, -18'sd65536, 0}},
      // full score, top index
      '{'{1, 0, 1, 8'd255, 17'd65536, 0, 0, 0, 1}, 1,
        '{1, 8'd255, 18'sd65536, -18'sd65536, 9'd1}},
      // oversized score then hint forcing a zero score
      '{'{1, 0, 0, 8'd1, 17'h1FFFF, -16'sd32768, 16'sd32767, 0, 0}, 0, none},
      '{'{1, 1, 1, 8'd2, 17'd0, 16'sd32767, -16'sd32768, 0, 1}, 1,
        '{1, 8'd2, 18'sd0, 18'sd131071, 9'd2}},
      // ordinary mix, runner-up tracking
      '{'{1, 0, 1, 8'd10, 17'd30000, 0, 0, 0, 0}, 0, none},
      '{'{1, 0, 1, 8'd11, 17'd40000, 0, 0, 0, 0}, 0, none},
      '{'{0, 1, 1, 8'd12, 17'd65536, 0, 0, 0, 0}, 0, none},
      '{'{1, 0, 0, 8'd13, 17'd35000, 0, 0, 0, 0}, 0, none},
      '{'{1, 0, 1, 8'd0, 17'd35000, 0, 0, 0, 1}, 0, none}
    };
    foreach (rows[i]) send_rec(rows[i].r, rows[i].typed, rows[i].p);

    // phased random frames across register settings
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      idle_mode = ph % 4;
      write_reg(REG_MODE, (ph != 0 && ph != 5));
      case (ph)
        1: begin
          write_reg(REG_TRK_X, 17'h08000); write_reg(REG_TRK_Y, 17'h07FFF);
          write_reg(REG_TRK_Z, 17'h08000); write_reg(REG_GATE, 0);
        end
        2: begin
          write_reg(REG_SHAPE_W, 0); write_reg(REG_TEMP_W, 0);
        end
        3: begin
          write_reg(REG_TRK_X, 17'h07FFF); write_reg(REG_TRK_Y, 17'h08000);
          write_reg(REG_TRK_Z, 17'h07FFF); write_reg(REG_GATE, 17'hFFFF);
          write_reg(REG_SHAPE_W, 17'h10000); write_reg(REG_TEMP_W, 0);
        end
        4: begin
          write_reg(REG_SHAPE_W, 0); write_reg(REG_TEMP_W, 17'h10000);
          write_reg(REG_GATE, 49);
        end
        default: begin
          write_reg(REG_TRK_X, 17'($urandom_range(0, 65535)));
          write_reg(REG_TRK_Y, 17'($urandom_range(0, 65535)));
          write_reg(REG_TRK_Z, 17'($urandom_range(0, 65535)));
          write_reg(REG_GATE, 17'($urandom_range(0, 3000)));
          write_reg(REG_SHAPE_W, 17'($urandom_range(0, 65536)));
          write_reg(REG_TEMP_W, 17'($urandom_range(0, 65536)));
        end
      endcase
      n = 0;
      while (n < 130) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
          r = rand_rec(k == len - 1);
          send_rec(r, 0, none);
          n++;
        end
      end
    end

    wait (picks_q.size() == 0);
    repeat (130) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
